// ===== src/utf8_fullwidth_fold_lowercase_unit_macros.svh =====
// Assertion macros used by the top-level RTL file of the full-width folding unit.
`ifndef UTF8_FULLWIDTH_FOLD_LOWERCASE_UNIT_MACROS_SVH
`define UTF8_FULLWIDTH_FOLD_LOWERCASE_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define UFWFOLD_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define UFWFOLD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/ufwfold_pkg.sv =====
`default_nettype none

package ufwfold_pkg;

  // Byte patterns of the three-byte UTF-8 groups.
  localparam logic [7:0] LEAD_MASK = 8'hF0;
  localparam logic [7:0] LEAD_CODE = 8'hE0;
  localparam logic [7:0] LEAD_BITS = 8'h0F;
  localparam logic [7:0] CONT_BITS = 8'h3F;

  // Code points that get folded.
  localparam logic [15:0] IDEO_SPACE = 16'h3000;
  localparam logic [15:0] FW_FIRST   = 16'hFF01;
  localparam logic [15:0] FW_LAST    = 16'hFF5E;
  localparam logic [15:0] FW_OFFSET  = 16'hFEE0;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA  = 8'd32;

  // Number of bytes of an open group held so far.
  typedef enum logic [1:0] {
    HELD_NONE   = 2'd0,
    HELD_LEAD   = 2'd1,
    HELD_SECOND = 2'd2
  } held_t;

  // Result bytes caused by one input byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] is sent first
    logic [1:0]      count;     // 0 to 3 bytes
    logic            end_flag;  // input byte closed the string
  } group_t;

  // Decoder status seen by the top level.
  typedef struct packed {
    held_t held_count;
  } dec_status_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
      r = b + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/utf8_fullwidth_fold_lowercase_unit.sv =====
`default_nettype none

// Full-width to half-width folding of a UTF-8 byte stream. One byte is taken
// per transaction and its result bytes leave on the next cycle, one per cycle
// while m_tready is high. A byte that only extends an open group gives no
// output; a byte that yields one output byte lets the next input follow in the
// next cycle if m_tready is high, and a byte that yields two or three output
// bytes (raw groups, or a string cut inside a group) holds the input back
// until the single result register sends its last byte. The lowercase_enable
// register is written through the cfg channel, which is always ready.
module utf8_fullwidth_fold_lowercase_unit (
  input  wire        clk,
  input  wire        rst,
  // Input stream
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // in_byte
  input  wire        s_tlast,   // string_end
  // Output stream
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // output_end
  output logic [0:0] m_tuser,   // run_last
  // Configuration
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [0:0] cfg_data   // lowercase_enable
);
  import ufwfold_pkg::*;

  `include "utf8_fullwidth_fold_lowercase_unit_macros.svh"

  logic        lowercase_enable;
  logic        take;
  logic        slot_free;
  group_t      grp;
  dec_status_t dec_status;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lowercase_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      lowercase_enable <= cfg_data[0];
    end
  end

  assign s_tready = slot_free;
  assign take     = s_tvalid && s_tready;

  ufwfold_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .in_byte          (s_tdata),
    .string_end       (s_tlast),
    .lowercase_enable (lowercase_enable),
    .grp              (grp),
    .status           (dec_status)
  );

  ufwfold_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (take && (grp.count != 2'd0)),
    .grp       (grp),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // The end of a string closes any open group.
  `UFWFOLD_ASSERT_NEXT(a_end_clears_group, take && s_tlast, dec_status.held_count == HELD_NONE, "group still open after string end")
  // A string end always yields output on the next cycle.
  `UFWFOLD_ASSERT_NEXT(a_end_has_output, take && s_tlast, m_tvalid, "string end gave no output")
  // The final byte of a string is also the last byte of its run.
  `UFWFOLD_ASSERT_SAME(a_end_is_run_last, m_tvalid && m_tlast, m_tuser[0], "output end without run end")
  // An empty result register never blocks the input.
  `UFWFOLD_ASSERT_SAME(a_idle_ready, !m_tvalid, s_tready, "input stalled with no output pending")

endmodule

`default_nettype wire

// ===== src/ufwfold_decode.sv =====
`default_nettype none

// Holds the open three-byte group and forms the result bytes of each byte.
module ufwfold_decode (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       take,
  input  wire  [7:0]                in_byte,
  input  wire                       string_end,
  input  wire                       lowercase_enable,
  output ufwfold_pkg::group_t       grp,
  output ufwfold_pkg::dec_status_t  status
);
  import ufwfold_pkg::*;

  held_t      held_count;
  held_t      held_count_next;
  logic [7:0] held_lead;
  logic [7:0] held_second;
  logic [15:0] code_point;
  logic [15:0] fw_sub;

  // Code point of a complete group, with the new byte as the third one.
  assign code_point = {(held_lead & LEAD_BITS), 8'h00} << 4
                    | ({8'h00, held_second & CONT_BITS} << 6)
                    | {8'h00, in_byte & CONT_BITS};
  assign fw_sub = code_point - FW_OFFSET;

  // Result bytes and next hold state.
  always_comb begin
    grp.bytes    = '0;
    grp.count    = 2'd0;
    grp.end_flag = string_end;
    held_count_next = held_count;
    unique case (held_count)
      HELD_NONE: begin
        if (((in_byte & LEAD_MASK) == LEAD_CODE) && !string_end) begin
          held_count_next = HELD_LEAD;
        end else begin
          grp.bytes[0] = fold_case(in_byte, lowercase_enable);
          grp.count    = 2'd1;
        end
      end
      HELD_LEAD: begin
        if (string_end) begin
          grp.bytes[0] = held_lead;
          grp.bytes[1] = fold_case(in_byte, lowercase_enable);
          grp.count    = 2'd2;
          held_count_next = HELD_NONE;
        end else begin
          held_count_next = HELD_SECOND;
        end
      end
      HELD_SECOND: begin
        if (code_point == IDEO_SPACE) begin
          grp.bytes[0] = ASCII_SPACE;
          grp.count    = 2'd1;
        end else if ((code_point >= FW_FIRST) && (code_point <= FW_LAST)) begin
          grp.bytes[0] = fold_case(fw_sub[7:0], lowercase_enable);
          grp.count    = 2'd1;
        end else begin
          grp.bytes[0] = held_lead;
          grp.bytes[1] = held_second;
          grp.bytes[2] = in_byte;
          grp.count    = 2'd3;
        end
        held_count_next = HELD_NONE;
      end
      default: begin
        held_count_next = HELD_NONE;
      end
    endcase
  end

  // Group state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
    end else if (take) begin
      held_count <= held_count_next;
    end
  end

  // Held bytes carry no reset; they are read only after being written.
  always_ff @(posedge clk) begin
    if (take && (held_count == HELD_NONE)) begin
      held_lead <= in_byte;
    end
    if (take && (held_count == HELD_LEAD)) begin
      held_second <= in_byte;
    end
  end

  assign status.held_count = held_count;

endmodule

`default_nettype wire

// ===== src/ufwfold_emit.sv =====
`default_nettype none

// Result register: holds the bytes of one input byte and sends them one a cycle while m_tready is high.
module ufwfold_emit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire ufwfold_pkg::group_t grp,
  output logic                 slot_free,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [0:0]           m_tuser
);
  import ufwfold_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      count;
  logic            end_flag;
  logic [1:0]      idx;
  logic            busy;
  logic            at_last;
  logic            pop;

  assign at_last   = (idx == (count - 2'd1));
  assign pop       = busy && m_tready;
  assign slot_free = !busy || (m_tready && at_last);

  // Control of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (push) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (pop && at_last) begin
      busy <= 1'b0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (push) begin
      bytes    <= grp.bytes;
      count    <= grp.count;
      end_flag <= grp.end_flag;
    end
  end

  assign m_tvalid   = busy;
  assign m_tdata    = bytes[idx];
  assign m_tuser[0] = at_last;
  assign m_tlast    = at_last && end_flag;

endmodule

`default_nettype wire
